// ===== rtl/lav_pkg.sv =====
package lav_pkg;

  // magnitude length that block scaling brings the largest component to
  localparam int SCALE_BITS     = 30;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DATA_WIDTH_DEF = 32;

endpackage

// ===== rtl/lav_scale.sv =====
module lav_scale import lav_pkg::*; #(
  parameter int IW = 33,
  parameter int SW = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  logic signed [IW-1:0]        vec [3],
  input  logic [SW-1:0]               side_in,
  output logic                        out_v,
  output logic [SCALE_BITS-1:0]       mag_out [3],
  output logic signed [SCALE_BITS:0]  sval_out [3],
  output logic [2:0]                  neg_out,
  output logic                        nz_out,
  output logic [SW-1:0]               side_out
);

  localparam int BW = $clog2(IW + 1);
  localparam int EW = IW + SCALE_BITS;

  logic [IW-1:0] m [3];
  logic [IW-1:0] or_m;
  logic [BW-1:0] blen;

  logic [IW-1:0] m_r [3];
  logic [2:0]    neg_r;
  logic [BW-1:0] blen_r;
  logic [SW-1:0] side_r;
  logic          v_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m[i] = vec[i][IW-1] ? IW'(~vec[i] + 1'b1) : IW'(vec[i]);
    end
    or_m = m[0] | m[1] | m[2];
    // bit length of the largest magnitude equals that of the OR
    blen = '0;
    for (int k = 0; k < IW; k++) begin
      if (or_m[k]) blen = BW'(k + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v_r   <= in_v;
      out_v <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_r[i]   <= m[i];
        neg_r[i] <= vec[i][IW-1];
      end
      blen_r <= blen;
      side_r <= side_in;
    end
  end

  logic [EW-1:0]         ext [3];
  logic [SCALE_BITS-1:0] sm  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext[i] = {m_r[i], {SCALE_BITS{1'b0}}} >> blen_r;
      sm[i]  = ext[i][SCALE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_out[i]  <= sm[i];
        sval_out[i] <= neg_r[i] ? -$signed({1'b0, sm[i]}) : $signed({1'b0, sm[i]});
      end
      neg_out  <= neg_r;
      nz_out   <= (blen_r != '0);
      side_out <= side_r;
    end
  end

endmodule

// ===== rtl/lav_norm.sv =====
module lav_norm import lav_pkg::*; #(
  parameter int IW = 33,
  parameter int SW = 8,
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  logic signed [IW-1:0] vec [3],
  input  logic [SW-1:0]        side_in,
  output logic                 out_v,
  output logic signed [FB+1:0] axis [3],
  output logic [SW-1:0]        side_out
);

  localparam int SB  = SCALE_BITS;
  localparam int SQW = 2 * SB + 2;
  localparam int RW  = 2 * SB + 3;
  localparam int NQ  = SB + 1;
  localparam int LW  = SB + 1;
  localparam int NW  = SB + FB + 1;
  localparam int ND  = FB + 1;
  localparam int CW  = SW + 4 + 3 * SB;
  localparam logic [FB:0] QONE = (FB + 1)'(1) << FB;

  logic          sc_v;
  logic [SB-1:0] sc_mag [3];
  logic signed [SB:0] sc_sval [3];
  logic [2:0]    sc_neg;
  logic          sc_nz;
  logic [SW-1:0] sc_side;

  lav_scale #(.IW(IW), .SW(SW)) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (in_v),
    .vec      (vec),
    .side_in  (side_in),
    .out_v    (sc_v),
    .mag_out  (sc_mag),
    .sval_out (sc_sval),
    .neg_out  (sc_neg),
    .nz_out   (sc_nz),
    .side_out (sc_side)
  );

  // carry word: side | nz | signs | magnitudes
  logic [CW-1:0] cw_sc;
  assign cw_sc = {sc_side, sc_nz, sc_neg, sc_mag[2], sc_mag[1], sc_mag[0]};

  logic [2*SB-1:0] sq_r [3];
  logic [CW-1:0]   cw_sq_r;
  logic            v_sq_r;
  logic [SQW-1:0]  sum_r;
  logic [CW-1:0]   cw_sum_r;
  logic            v_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_sq_r  <= 1'b0;
      v_sum_r <= 1'b0;
    end else if (en) begin
      v_sq_r  <= sc_v;
      v_sum_r <= v_sq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= sc_mag[i] * sc_mag[i];
      end
      cw_sq_r  <= cw_sc;
      sum_r    <= SQW'(sq_r[0]) + SQW'(sq_r[1]) + SQW'(sq_r[2]);
      cw_sum_r <= cw_sq_r;
    end
  end

  // integer square root, one result bit per stage
  logic [SQW-1:0] qx_r   [NQ];
  logic [RW-1:0]  qres_r [NQ];
  logic [CW-1:0]  qc_r   [NQ];
  logic [NQ-1:0]  qv_r;

  for (genvar j = 0; j < NQ; j++) begin : g_sqrt
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SB - j));
    logic [SQW-1:0] x_i;
    logic [RW-1:0]  r_i;
    logic [RW-1:0]  t;
    logic [CW-1:0]  c_i;
    logic           v_i;

    if (j == 0) begin : g_first
      assign x_i = sum_r;
      assign r_i = '0;
      assign c_i = cw_sum_r;
      assign v_i = v_sum_r;
    end else begin : g_next
      assign x_i = qx_r[j-1];
      assign r_i = qres_r[j-1];
      assign c_i = qc_r[j-1];
      assign v_i = qv_r[j-1];
    end

    assign t = r_i + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        qv_r[j] <= 1'b0;
      end else if (en) begin
        qv_r[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (RW'(x_i) >= t) begin
          qx_r[j]   <= x_i - SQW'(t);
          qres_r[j] <= (r_i >> 1) + BIT;
        end else begin
          qx_r[j]   <= x_i;
          qres_r[j] <= r_i >> 1;
        end
        qc_r[j] <= c_i;
      end
    end
  end

  logic [LW-1:0] len;
  logic [CW-1:0] cw_q;
  assign len  = qres_r[NQ-1][LW-1:0];
  assign cw_q = qc_r[NQ-1];

  logic [NW-1:0] num_r [3];
  logic [LW-1:0] len_r;
  logic [CW-1:0] cw_p_r;
  logic          v_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_p_r <= 1'b0;
    end else if (en) begin
      v_p_r <= qv_r[NQ-1];
    end
  end

  // rounded numerator: mag * 2^FB + len / 2
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= (NW'(cw_q[i*SB +: SB]) << FB) + NW'(len >> 1);
      end
      len_r  <= len;
      cw_p_r <= cw_q;
    end
  end

  // restoring division, one quotient bit per stage on each lane
  logic [NW-1:0] dnum_r [ND][3];
  logic [LW-1:0] drem_r [ND][3];
  logic [FB:0]   dq_r   [ND][3];
  logic [LW-1:0] dlen_r [ND];
  logic [CW-1:0] dc_r   [ND];
  logic [ND-1:0] dv_r;

  for (genvar k = 0; k < ND; k++) begin : g_div
    logic [NW-1:0] num_i [3];
    logic [LW-1:0] rem_i [3];
    logic [FB:0]   q_i   [3];
    logic [LW:0]   t     [3];
    logic [2:0]    ge;
    logic [LW-1:0] len_i;
    logic [CW-1:0] c_i;
    logic          v_i;

    if (k == 0) begin : g_first
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign num_i[i] = num_r[i];
        assign rem_i[i] = LW'(num_r[i][NW-1:FB+1]);
        assign q_i[i]   = '0;
      end
      assign len_i = len_r;
      assign c_i   = cw_p_r;
      assign v_i   = v_p_r;
    end else begin : g_next
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign num_i[i] = dnum_r[k-1][i];
        assign rem_i[i] = drem_r[k-1][i];
        assign q_i[i]   = dq_r[k-1][i];
      end
      assign len_i = dlen_r[k-1];
      assign c_i   = dc_r[k-1];
      assign v_i   = dv_r[k-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]  = {rem_i[i], num_i[i][FB-k]};
        ge[i] = (t[i] >= {1'b0, len_i});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else if (en) begin
        dv_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dnum_r[k][i] <= num_i[i];
          drem_r[k][i] <= ge[i] ? LW'(t[i] - {1'b0, len_i}) : LW'(t[i]);
          dq_r[k][i]   <= {q_i[i][FB-1:0], ge[i]};
        end
        dlen_r[k] <= len_i;
        dc_r[k]   <= c_i;
      end
    end
  end

  logic [CW-1:0] cw_d;
  logic [FB:0]   qc [3];
  assign cw_d = dc_r[ND-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dq_r[ND-1][i] > QONE) ? QONE : dq_r[ND-1][i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= dv_r[ND-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (!cw_d[3*SB+3]) begin
          axis[i] <= '0;
        end else if (cw_d[3*SB+i]) begin
          axis[i] <= -$signed({1'b0, qc[i]});
        end else begin
          axis[i] <= $signed({1'b0, qc[i]});
        end
      end
      side_out <= cw_d[3*SB+4 +: SW];
    end
  end

endmodule

// ===== rtl/lav_cross.sv =====
module lav_cross #(
  parameter int AW = 31,
  parameter int BW = 18,
  parameter int SW = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_v,
  input  logic signed [AW-1:0]    a [3],
  input  logic signed [BW-1:0]    b [3],
  input  logic [SW-1:0]           side_in,
  output logic                    out_v,
  output logic signed [AW+BW:0]   r [3],
  output logic [SW-1:0]           side_out
);

  localparam int PW = AW + BW;

  logic signed [PW-1:0] p_r [6];
  logic [SW-1:0]        side_r;
  logic                 v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v_r   <= in_v;
      out_v <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= a[1] * b[2];
      p_r[1] <= a[2] * b[1];
      p_r[2] <= a[2] * b[0];
      p_r[3] <= a[0] * b[2];
      p_r[4] <= a[0] * b[1];
      p_r[5] <= a[1] * b[0];
      side_r <= side_in;
      for (int i = 0; i < 3; i++) begin
        r[i] <= (PW + 1)'(p_r[2*i]) - (PW + 1)'(p_r[2*i+1]);
      end
      side_out <= side_r;
    end
  end

endmodule

// ===== rtl/lav_xlate.sv =====
module lav_xlate import lav_pkg::*; #(
  parameter int FB = FRAC_BITS_DEF,
  parameter int DW = DATA_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  logic signed [FB+1:0] ax [3][3],
  input  logic [3*DW-1:0]      eye,
  output logic                 out_v,
  output logic signed [FB+1:0] axo [3][3],
  output logic signed [DW-1:0] shift [3]
);

  localparam int AXW = FB + 2;
  localparam int EHW = DW - FB;
  localparam int PHW = AXW + EHW;
  localparam int PLW = AXW + FB + 1;
  localparam int HW  = PHW + 2;
  localparam int LOW = PLW + 2;
  localparam int XW  = DW + 6;
  localparam logic signed [LOW:0]  HALF_L = (LOW + 1)'(1) << (FB - 1);
  localparam logic signed [XW-1:0] SMAX   = (XW'(1) << (DW - 1)) - XW'(1);
  localparam logic signed [XW-1:0] SMIN   = -(XW'(1) << (DW - 1));

  logic signed [EHW-1:0] eh [3];
  logic signed [FB:0]    el [3];

  logic signed [PHW-1:0] ph_r [3][3];
  logic signed [PLW-1:0] pl_r [3][3];
  logic signed [HW-1:0]  hi_r [3];
  logic signed [LOW-1:0] lo_r [3];
  logic signed [AXW-1:0] ax1_r [3][3];
  logic signed [AXW-1:0] ax2_r [3][3];
  logic [1:0]            v_r;

  // eye split into integer part (floor) and fraction so products stay narrow
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      eh[c] = $signed(eye[c*DW+FB +: EHW]);
      el[c] = $signed({1'b0, eye[c*DW +: FB]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      out_v <= 1'b0;
    end else if (en) begin
      v_r   <= {v_r[0], in_v};
      out_v <= v_r[1];
    end
  end

  logic signed [LOW:0]   nl [3];
  logic signed [LOW:0]   rl [3];
  logic signed [XW-1:0]  rs [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      nl[a] = -((LOW + 1)'(lo_r[a]));
      rl[a] = (nl[a] + HALF_L) >>> FB;
      rs[a] = XW'(rl[a]) - XW'(hi_r[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int c = 0; c < 3; c++) begin
          ph_r[a][c]  <= ax[a][c] * eh[c];
          pl_r[a][c]  <= ax[a][c] * el[c];
          ax1_r[a][c] <= ax[a][c];
          ax2_r[a][c] <= ax1_r[a][c];
          axo[a][c]   <= ax2_r[a][c];
        end
        hi_r[a] <= HW'(ph_r[a][0]) + HW'(ph_r[a][1]) + HW'(ph_r[a][2]);
        lo_r[a] <= LOW'(pl_r[a][0]) + LOW'(pl_r[a][1]) + LOW'(pl_r[a][2]);
        if (rs[a] > SMAX) begin
          shift[a] <= SMAX[DW-1:0];
        end else if (rs[a] < SMIN) begin
          shift[a] <= SMIN[DW-1:0];
        end else begin
          shift[a] <= rs[a][DW-1:0];
        end
      end
    end
  end

endmodule

// ===== rtl/lookat_view_matrix.sv =====
// Look-at view basis, fully pipelined.
// Its depth comes mostly from the two normalize units:
// a square-root stage per result bit and a divide stage per quotient bit.
// Throughput: one transaction per cycle while the output is not stalled; a stall at the output freezes every stage.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
module lookat_view_matrix import lav_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, hint_up_x, hint_up_y, hint_up_z
  input  logic [((9*DATA_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // right_x, right_y, right_z, upaxis_x, upaxis_y, upaxis_z, back_x, back_y, back_z,
  // shift_x, shift_y, shift_z
  output logic [((9*(FRAC_BITS+2)+3*DATA_WIDTH+7)/8)*8-1:0] out_tdata
);

  localparam int DW     = DATA_WIDTH;
  localparam int FB     = FRAC_BITS;
  localparam int SB     = SCALE_BITS;
  localparam int AXW    = FB + 2;
  localparam int DIRW   = DW + 1;
  localparam int UPW    = SB + 1;
  localparam int RCW    = UPW + AXW + 1;
  localparam int UAW    = 2 * AXW + 1;
  localparam int OUT_DW = 9 * AXW + 3 * DW;
  localparam int OUT_W  = ((OUT_DW + 7) / 8) * 8;
  localparam int SWA    = 3 * DW + 3 * DIRW;
  localparam int SWB    = 3 * DW + 3 * UPW;
  localparam int SWC    = 3 * DW + 3 * AXW;
  localparam int SWE    = 3 * DW + 6 * AXW;
  localparam logic signed [UAW:0] UA_HALF = (UAW + 1)'(1) << (FB - 1);
  localparam logic signed [UAW:0] UA_ONE  = (UAW + 1)'(1) << FB;
  localparam logic signed [AXW-1:0] AX_ONE = AXW'(1) << FB;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // input register: eye kept packed, direction formed here
  logic [3*DW-1:0]          eye_r;
  logic signed [DIRW-1:0]   dir_r [3];
  logic signed [DW-1:0]     up_r  [3];
  logic                     v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eye_r <= in_tdata[3*DW-1:0];
      for (int i = 0; i < 3; i++) begin
        dir_r[i] <= $signed({in_tdata[i*DW+DW-1], in_tdata[i*DW +: DW]})
                  - $signed({in_tdata[(3+i)*DW+DW-1], in_tdata[(3+i)*DW +: DW]});
        up_r[i]  <= in_tdata[(6+i)*DW +: DW];
      end
    end
  end

  // scale the up hint
  logic [SWA-1:0]         side_a_in, side_a;
  logic                   va;
  logic [SB-1:0]          ua_mag [3];
  logic signed [SB:0]     ups_a [3];
  logic [2:0]             ua_neg;
  logic                   ua_nz;
  logic signed [DIRW-1:0] dir_a [3];
  logic [3*DW-1:0]        eye_a;

  for (genvar i = 0; i < 3; i++) begin : g_pa
    assign side_a_in[i*DIRW +: DIRW] = dir_r[i];
    assign dir_a[i] = side_a[i*DIRW +: DIRW];
  end
  assign side_a_in[3*DIRW +: 3*DW] = eye_r;
  assign eye_a = side_a[3*DIRW +: 3*DW];

  lav_scale #(.IW(DW), .SW(SWA)) u_upscale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (v0_r),
    .vec      (up_r),
    .side_in  (side_a_in),
    .out_v    (va),
    .mag_out  (ua_mag),
    .sval_out (ups_a),
    .neg_out  (ua_neg),
    .nz_out   (ua_nz),
    .side_out (side_a)
  );

  // back axis
  logic [SWB-1:0]         side_b_in, side_b;
  logic                   vb;
  logic signed [AXW-1:0]  back_b [3];
  logic signed [UPW-1:0]  ups_b [3];
  logic [3*DW-1:0]        eye_b;

  for (genvar i = 0; i < 3; i++) begin : g_pb
    assign side_b_in[i*UPW +: UPW] = ups_a[i];
    assign ups_b[i] = side_b[i*UPW +: UPW];
  end
  assign side_b_in[3*UPW +: 3*DW] = eye_a;
  assign eye_b = side_b[3*UPW +: 3*DW];

  lav_norm #(.IW(DIRW), .SW(SWB), .FB(FB)) u_norm_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (va),
    .vec      (dir_a),
    .side_in  (side_b_in),
    .out_v    (vb),
    .axis     (back_b),
    .side_out (side_b)
  );

  // cross(up, back)
  logic [SWC-1:0]         side_c_in, side_c;
  logic                   vc;
  logic signed [RCW-1:0]  rc_c [3];

  for (genvar i = 0; i < 3; i++) begin : g_pc
    assign side_c_in[i*AXW +: AXW] = back_b[i];
  end
  assign side_c_in[3*AXW +: 3*DW] = eye_b;

  lav_cross #(.AW(UPW), .BW(AXW), .SW(SWC)) u_cross_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (vb),
    .a        (ups_b),
    .b        (back_b),
    .side_in  (side_c_in),
    .out_v    (vc),
    .r        (rc_c),
    .side_out (side_c)
  );

  // right axis
  logic [SWC-1:0]         side_d;
  logic                   vd;
  logic signed [AXW-1:0]  right_d [3];
  logic signed [AXW-1:0]  back_d [3];
  logic [3*DW-1:0]        eye_d;

  lav_norm #(.IW(RCW), .SW(SWC), .FB(FB)) u_norm_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (vc),
    .vec      (rc_c),
    .side_in  (side_c),
    .out_v    (vd),
    .axis     (right_d),
    .side_out (side_d)
  );

  for (genvar i = 0; i < 3; i++) begin : g_pd
    assign back_d[i] = side_d[i*AXW +: AXW];
  end
  assign eye_d = side_d[3*AXW +: 3*DW];

  // cross(back, right)
  logic [SWE-1:0]         side_e_in, side_e;
  logic                   ve;
  logic signed [UAW-1:0]  uraw_e [3];
  logic signed [AXW-1:0]  back_e [3];
  logic signed [AXW-1:0]  right_e [3];
  logic [3*DW-1:0]        eye_e;

  for (genvar i = 0; i < 3; i++) begin : g_pe
    assign side_e_in[i*AXW +: AXW]       = back_d[i];
    assign side_e_in[(3+i)*AXW +: AXW]   = right_d[i];
    assign back_e[i]  = side_e[i*AXW +: AXW];
    assign right_e[i] = side_e[(3+i)*AXW +: AXW];
  end
  assign side_e_in[6*AXW +: 3*DW] = eye_d;
  assign eye_e = side_e[6*AXW +: 3*DW];

  lav_cross #(.AW(AXW), .BW(AXW), .SW(SWE)) u_cross_up (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (vd),
    .a        (back_d),
    .b        (right_d),
    .side_in  (side_e_in),
    .out_v    (ve),
    .r        (uraw_e),
    .side_out (side_e)
  );

  // up axis: round to FB fraction bits, clamp to unit range
  logic signed [UAW:0]    ua_s [3];
  logic signed [AXW-1:0]  ua_c [3];
  logic signed [AXW-1:0]  ua_r [3];
  logic signed [AXW-1:0]  back_u_r [3];
  logic signed [AXW-1:0]  right_u_r [3];
  logic [3*DW-1:0]        eye_u_r;
  logic                   vu_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ua_s[i] = ((UAW + 1)'(uraw_e[i]) + UA_HALF) >>> FB;
      if (ua_s[i] > UA_ONE) begin
        ua_c[i] = AX_ONE;
      end else if (ua_s[i] < -UA_ONE) begin
        ua_c[i] = -AX_ONE;
      end else begin
        ua_c[i] = ua_s[i][AXW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vu_r <= 1'b0;
    end else if (en) begin
      vu_r <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ua_r[i]      <= ua_c[i];
        back_u_r[i]  <= back_e[i];
        right_u_r[i] <= right_e[i];
      end
      eye_u_r <= eye_e;
    end
  end

  // translation
  logic signed [AXW-1:0] ax_x [3][3];
  logic signed [AXW-1:0] axo  [3][3];
  logic signed [DW-1:0]  sh   [3];

  for (genvar i = 0; i < 3; i++) begin : g_px
    assign ax_x[0][i] = right_u_r[i];
    assign ax_x[1][i] = ua_r[i];
    assign ax_x[2][i] = back_u_r[i];
  end

  lav_xlate #(.FB(FB), .DW(DW)) u_xlate (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (vu_r),
    .ax    (ax_x),
    .eye   (eye_u_r),
    .out_v (out_tvalid),
    .axo   (axo),
    .shift (sh)
  );

  for (genvar i = 0; i < 3; i++) begin : g_out
    assign out_tdata[i*AXW +: AXW]         = axo[0][i];
    assign out_tdata[(3+i)*AXW +: AXW]     = axo[1][i];
    assign out_tdata[(6+i)*AXW +: AXW]     = axo[2][i];
    assign out_tdata[9*AXW + i*DW +: DW]   = sh[i];
  end
  if (OUT_W > OUT_DW) begin : g_pad
    assign out_tdata[OUT_W-1:OUT_DW] = '0;
  end

  for (genvar i = 0; i < 3; i++) begin : g_chk
    a_right_unit: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid |-> (axo[0][i] <= AX_ONE) && (axo[0][i] >= -AX_ONE))
      else $error("right axis component outside unit range");
  end

  a_zero_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (axo[2][0] == '0) && (axo[2][1] == '0) && (axo[2][2] == '0)
    |-> (axo[0][0] == '0) && (axo[0][1] == '0) && (axo[0][2] == '0)
        && (sh[0] == '0) && (sh[1] == '0) && (sh[2] == '0))
    else $error("zero back axis must give zero right axis and translation");

  a_zero_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (axo[0][0] == '0) && (axo[0][1] == '0) && (axo[0][2] == '0)
    |-> (axo[1][0] == '0) && (axo[1][1] == '0) && (axo[1][2] == '0)
        && (sh[0] == '0) && (sh[1] == '0))
    else $error("zero right axis must give zero up axis and x/y translation");

endmodule

// ===== tb/sv/lookat_view_matrix_tb.sv =====
`timescale 1ns / 100ps

module lookat_view_matrix_tb;
  import lav_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int DW = DATA_WIDTH_DEF;
  localparam int AW = FB + 2;
  localparam int IN_W = ((9*DW+7)/8)*8;
  localparam int OUT_W = ((9*AW+3*DW+7)/8)*8;
  localparam int LATENCY = 2*(FB + 30) + 27;
  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 530;

  typedef logic signed [63:0] s64_t;

  typedef struct packed {
    logic signed [DW-1:0] sz, sy, sx;
    logic signed [AW-1:0] bz, by, bx;
    logic signed [AW-1:0] uz, uy, ux;
    logic signed [AW-1:0] rz, ry, rx;
  } view_basis_t;

  // magnitude of a 64-bit value
  function automatic logic [63:0] mag64(s64_t x);
    return x < 0 ? -x : x;
  endfunction

  function automatic s64_t floor_div_pow2(s64_t x, int k);
    if (x >= 0) return x >>> k;
    return -s64_t'((mag64(x) + ((64'd1 << k) - 1)) >> k);
  endfunction

  function automatic s64_t round_q(s64_t x);
    return floor_div_pow2(x + (64'sd1 <<< (FB-1)), FB);
  endfunction

  function automatic bit scale_to_30(s64_t v[3], output s64_t o[3]);
    logic [63:0] m, a;
    int b;
    m = 0;
    b = 0;
    for (int i = 0; i < 3; i++) if (mag64(v[i]) > m) m = mag64(v[i]);
    if (m == 0) begin
      o[0] = 0; o[1] = 0; o[2] = 0;
      return 0;
    end
    while (b < 64 && (m >> b) != 0) b++;
    for (int i = 0; i < 3; i++) begin
      a = mag64(v[i]);
      if (b > SCALE_BITS) a = a >> (b - SCALE_BITS);
      else a = a << (SCALE_BITS - b);
      o[i] = v[i] < 0 ? -s64_t'(a) : s64_t'(a);
    end
    return 1;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic void unit_vec(s64_t v[3], output s64_t o[3]);
    s64_t s[3];
    logic [63:0] sum, len, q;
    sum = 0;
    if (!scale_to_30(v, s)) begin
      o[0] = 0; o[1] = 0; o[2] = 0;
      return;
    end
    for (int i = 0; i < 3; i++) sum += mag64(s[i]) * mag64(s[i]);
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag64(s[i]) << FB) + (len >> 1)) / len;
      if (q > (64'd1 << FB)) q = 64'd1 << FB;
      o[i] = s[i] < 0 ? -s64_t'(q) : s64_t'(q);
    end
  endfunction

  function automatic void cross_prod(s64_t a[3], s64_t b[3], output s64_t r[3]);
    r[0] = a[1]*b[2] - a[2]*b[1];
    r[1] = a[2]*b[0] - a[0]*b[2];
    r[2] = a[0]*b[1] - a[1]*b[0];
  endfunction

  function automatic s64_t eye_shift(s64_t ax[3], s64_t eh[3], s64_t el[3]);
    s64_t hi, lo, r, maxv;
    hi = 0;
    lo = 0;
    maxv = (64'sd1 <<< (DW-1)) - 1;
    for (int i = 0; i < 3; i++) begin
      hi += ax[i] * eh[i];
      lo += ax[i] * el[i];
    end
    r = -hi + round_q(-lo);
    if (r > maxv) r = maxv;
    if (r < -maxv - 1) r = -maxv - 1;
    return r;
  endfunction

  function automatic view_basis_t compute_view(logic [IN_W-1:0] d);
    s64_t eye[3], dir[3], up[3], ups[3], bk[3], rc[3], rt[3], ua[3], eh[3], el[3];
    s64_t one;
    view_basis_t v;
    one = 64'sd1 <<< FB;
    for (int i = 0; i < 3; i++) begin
      eye[i] = s64_t'($signed(d[i*DW +: DW]));
      dir[i] = eye[i] - s64_t'($signed(d[(3+i)*DW +: DW]));
      up[i] = s64_t'($signed(d[(6+i)*DW +: DW]));
      eh[i] = floor_div_pow2(eye[i], FB);
      el[i] = eye[i] & ((64'sd1 <<< FB) - 1);
    end
    unit_vec(dir, bk);
    void'(scale_to_30(up, ups));
    cross_prod(ups, bk, rc);
    unit_vec(rc, rt);
    cross_prod(bk, rt, ua);
    for (int i = 0; i < 3; i++) begin
      ua[i] = round_q(ua[i]);
      if (ua[i] > one) ua[i] = one;
      if (ua[i] < -one) ua[i] = -one;
    end
    v.rx = AW'(rt[0]); v.ry = AW'(rt[1]); v.rz = AW'(rt[2]);
    v.ux = AW'(ua[0]); v.uy = AW'(ua[1]); v.uz = AW'(ua[2]);
    v.bx = AW'(bk[0]); v.by = AW'(bk[1]); v.bz = AW'(bk[2]);
    v.sx = DW'(eye_shift(rt, eh, el));
    v.sy = DW'(eye_shift(ua, eh, el));
    v.sz = DW'(eye_shift(bk, eh, el));
    return v;
  endfunction

  class view_scoreboard;
    view_basis_t pending_views[$];
    int errors;

    function void note_camera(logic [IN_W-1:0] d);
      pending_views = {pending_views, compute_view(d)};
    endfunction

    function void check_view(logic [OUT_W-1:0] d);
      view_basis_t got, exp;
      got = d[$bits(view_basis_t)-1:0];
      if (pending_views.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected output transaction %h", got);
        return;
      end
      exp = pending_views.pop_front();
      if (got !== exp || d[OUT_W-1:$bits(view_basis_t)] !== '0) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: right exp %0d %0d %0d got %0d %0d %0d",
                   exp.rx, exp.ry, exp.rz, got.rx, got.ry, got.rz);
          $display("       upaxis exp %0d %0d %0d got %0d %0d %0d",
                   exp.ux, exp.uy, exp.uz, got.ux, got.uy, got.uz);
          $display("       back exp %0d %0d %0d got %0d %0d %0d",
                   exp.bx, exp.by, exp.bz, got.bx, got.by, got.bz);
          $display("       shift exp %0d %0d %0d got %0d %0d %0d",
                   exp.sx, exp.sy, exp.sz, got.sx, got.sy, got.sz);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_W-1:0] out_tdata;

  view_scoreboard sb = new();
  bit calm = 0;       // no idling in the last part
  bit hold_off = 0;   // long output stall request
  int idle_cycles = 0;

  always #1 clk = ~clk;

  lookat_view_matrix uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_camera(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_view(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 0;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 0;
        n = $urandom_range(1, 14);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_tready <= 1;
      end
    end
  end

  task automatic send_camera(logic [IN_W-1:0] d);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      n = $urandom_range(1, 14);
      repeat (n) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [DW-1:0] rand_word(int kind);
    case (kind)
      0: return {DW{1'b0}};
      1: return {1'b0, {(DW-1){1'b1}}};
      2: return {1'b1, {(DW-1){1'b0}}};
      3: return $urandom_range(0, 1) ? DW'($urandom_range(0, 1 << 20))
                                     : -DW'($urandom_range(0, 1 << 20));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [IN_W-1:0] pack_cam(logic [DW-1:0] w[9]);
    logic [IN_W-1:0] d;
    d = '0;
    for (int i = 0; i < 9; i++) d[i*DW +: DW] = w[i];
    return d;
  endfunction

  initial begin
    logic [DW-1:0] w[9];
    logic [DW-1:0] mx, mn, one;
    int k;
    mx = {1'b0, {(DW-1){1'b1}}};
    mn = {1'b1, {(DW-1){1'b0}}};
    one = DW'(1) << FB;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: plain camera
    w = '{0, 0, 5*one, 0, 0, 0, 0, one, 0}; send_camera(pack_cam(w));
    // eye equals target
    w = '{one, 2*one, 3*one, one, 2*one, 3*one, 0, one, 0}; send_camera(pack_cam(w));
    // zero up hint
    w = '{one, 0, 0, 0, 0, 0, 0, 0, 0}; send_camera(pack_cam(w));
    // up parallel to view
    w = '{0, 4*one, 0, 0, 0, 0, 0, one, 0}; send_camera(pack_cam(w));
    // extremes, saturating shifts
    w = '{mx, mx, mx, mn, mn, mn, mx, mn, 0}; send_camera(pack_cam(w));
    w = '{mn, mn, mn, mx, mx, mx, mn, mx, mx}; send_camera(pack_cam(w));
    w = '{mx, mn, mx, 0, 0, 0, 1, 0, mn}; send_camera(pack_cam(w));
    w = '{mn, 0, 0, mx, 0, 0, 0, 0, mx}; send_camera(pack_cam(w));
    w = '{1, 0, 0, 0, 0, 0, 0, 1, 0}; send_camera(pack_cam(w));
    w = '{-1, -1, -1, 0, 0, 0, 0, 0, -1}; send_camera(pack_cam(w));
    w = '{'1, '1, '1, '1, '1, 0, '1, '1, '1}; send_camera(pack_cam(w));
    w = '{3*one, -2*one, one, -one, one, 0, one, one, one}; send_camera(pack_cam(w));

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 100) hold_off = 1;
      if (n == N_RANDOM - 80) calm = 1;
      k = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) w[i] = rand_word(k < 6 ? 3 + (k & 1) : $urandom_range(0, 4));
      if (k == 9) for (int i = 0; i < 3; i++) w[3+i] = w[i];
      if (k == 8) for (int i = 0; i < 3; i++) w[6+i] = 0;
      send_camera(pack_cam(w));
    end
    in_tvalid <= 0;

    while (sb.pending_views.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_views.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
